[hw/rtl/wssl_pkg.sv]
package wssl_pkg;

    // Operation codes
    localparam logic [2:0] OP_QUERY      = 3'd0;
    localparam logic [2:0] OP_WRITE_SLOT = 3'd1;
    localparam logic [2:0] OP_DEL_SLOT   = 3'd2;
    localparam logic [2:0] OP_SET_MODE   = 3'd3;
    localparam logic [2:0] OP_NEXT_MODE  = 3'd4;
    localparam logic [2:0] OP_SET_MANUAL = 3'd5;

    // Heater modes
    localparam logic [1:0] HEAT_OFF    = 2'd0;
    localparam logic [1:0] HEAT_AUTO   = 2'd1;
    localparam logic [1:0] HEAT_MANUAL = 2'd2;
    localparam logic [1:0] HEAT_RSVD   = 2'd3;

    // Answer origins
    localparam logic [1:0] SRC_OFF     = 2'd0;
    localparam logic [1:0] SRC_ENTRY   = 2'd1;
    localparam logic [1:0] SRC_DEFAULT = 2'd2;

    // Temperatures in tenths of a degree
    localparam logic [8:0] MANUAL_MIN     = 9'd70;
    localparam logic [8:0] MANUAL_MAX     = 9'd260;
    localparam logic [8:0] DEFAULT_TEMP_RST = 9'd171;
    localparam logic [7:0] DEFAULT_PRIO   = 8'd9;

    // Time constants in minutes
    localparam logic [15:0]        MIN_PER_DAY = 16'd1440;
    localparam logic signed [15:0] NO_DISTANCE = 16'sd20160;

    typedef struct packed {
        logic [2:0] operation;
        logic [2:0] slot;
        logic [2:0] weekday;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [6:0] day_mask;
        logic [8:0] setpoint;
        logic [7:0] priority_req;
        logic [1:0] mode_value;
    } wssl_in_t;

    typedef struct packed {
        logic [1:0] source;
        logic [2:0] chosen_slot;
        logic [8:0] target_temp;
        logic [7:0] target_priority;
        logic [1:0] mode_now;
    } wssl_out_t;

    // One schedule entry as held in the table memory
    typedef struct packed {
        logic [6:0]  days;
        logic [10:0] at_min;
        logic [8:0]  temp;
        logic [7:0]  prio;
    } wssl_entry_t;

    // hour*60 + minute, taken literally (up to 1923)
    function automatic logic [10:0] minutes_of(input logic [4:0] hr, input logic [5:0] mn);
        logic [10:0] h;
        begin
            h = {6'b0, hr};
            minutes_of = (h << 6) - (h << 2) + {5'b0, mn};
        end
    endfunction

endpackage

[hw/rtl/weekly_setpoint_schedule_lookup.sv]
// Weekly thermostat setpoint schedule.
// Input channel s_valid/s_ready/s_data carries one command word (query, write
// slot, delete slot, set mode, next mode, set manual temperature); the result
// channel m_valid/m_ready/m_data returns exactly one word per command.
// A query in AUTO mode walks the schedule table one slot per cycle
// through a single distance/compare unit fed by the table memory's registered
// read port, then moves to the final step; every other command goes straight
// from idle to the final step, where its result is loaded into the output.
// s_ready is high only while the sequencer is idle, so one command is in
// flight at a time.
// The result sits in an output register; the next command is taken while it
// waits. If the receiver stalls and a second result is ready, the sequencer
// holds in its final step (state updates included) until the register frees.
// Reset (aresetn low, synchronous) clears all slot valid bits, sets AUTO mode
// and a default setpoint of 17.1 degrees, and empties the output register.
// Table contents need no clearing: a slot's contents are only used once written.
module weekly_setpoint_schedule_lookup #(
    parameter int SLOTS = 8
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  wssl_pkg::wssl_in_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output wssl_pkg::wssl_out_t m_data
);

    import wssl_pkg::*;

    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);
    localparam int EW = $bits(wssl_entry_t);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    logic [1:0]  state_reg, state_next;
    wssl_in_t    item_reg;
    logic [10:0] now_reg;
    logic [CW-1:0] cnt_reg;
    logic        pend_reg;
    logic        pend_valid_reg;
    logic [AW-1:0] pend_idx_reg;
    logic signed [15:0] best_reg;
    logic        found_reg;
    logic [AW-1:0] pick_reg;
    logic [8:0]  pick_temp_reg;
    logic [7:0]  pick_prio_reg;
    logic [SLOTS-1:0] valid_bits_reg;
    logic [1:0]  heater_mode_reg, heater_mode_next;
    logic [8:0]  default_temp_reg, default_temp_next;
    logic        m_valid_reg;
    wssl_out_t   m_data_reg;

    logic        out_free;
    logic        finish_go;
    logic        slot_ok;
    logic [AW-1:0] slot_addr;
    logic [AW-1:0] rd_addr;
    logic        ram_we;
    wssl_entry_t wr_entry;
    logic [EW-1:0] rd_word;
    wssl_entry_t rd_entry;
    wssl_out_t   result;

    // distance unit signals
    logic signed [11:0] diff;
    logic        at_le_now;
    logic        at_ge_now;
    logic [6:0]  low_m;
    logic [6:0]  high_m;
    logic        hit_lo;
    logic        hit_hi;
    logic [2:0]  d_lo;
    logic [2:0]  d_hi;
    logic [2:0]  days_back;
    logic [15:0] day_base;
    logic signed [15:0] back_min;
    logic        better;

    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;
    assign out_free = !m_valid_reg || m_ready;
    assign finish_go = (state_reg == ST_FINISH) && out_free;

    assign slot_ok   = (32'(item_reg.slot) < SLOTS);
    assign slot_addr = AW'(item_reg.slot);
    assign rd_addr   = cnt_reg[AW-1:0];

    // table write on a slot write command
    assign ram_we = finish_go && (item_reg.operation == OP_WRITE_SLOT) && slot_ok;
    always_comb begin
        wr_entry.days   = item_reg.day_mask;
        wr_entry.at_min = minutes_of(item_reg.hour, item_reg.minute);
        wr_entry.temp   = item_reg.setpoint;
        wr_entry.prio   = item_reg.priority_req;
    end

    wssl_ram #(
        .WIDTH(EW),
        .DEPTH(SLOTS)
    ) u_table (
        .clk  (aclk),
        .we   (ram_we),
        .waddr(slot_addr),
        .wdata(wr_entry),
        .raddr(rd_addr),
        .rdata(rd_word)
    );

    assign rd_entry = wssl_entry_t'(rd_word);

    // Distance unit: minutes back to the entry's latest past occurrence
    always_comb begin
        diff      = $signed({1'b0, now_reg}) - $signed({1'b0, rd_entry.at_min});
        at_le_now = !diff[11];
        at_ge_now = diff[11] || (diff == 12'sd0);
        for (int i = 0; i < 7; i++) begin
            low_m[i]  = rd_entry.days[i] && ((3'(i) < item_reg.weekday) ||
                        ((3'(i) == item_reg.weekday) && at_le_now));
            high_m[i] = rd_entry.days[i] && ((3'(i) > item_reg.weekday) ||
                        ((3'(i) == item_reg.weekday) && at_ge_now));
        end
        // highest matching day on each side
        hit_lo = 1'b0;
        hit_hi = 1'b0;
        d_lo   = 3'd0;
        d_hi   = 3'd0;
        for (int i = 0; i < 7; i++) begin
            if (low_m[i]) begin
                hit_lo = 1'b1;
                d_lo   = 3'(i);
            end
            if (high_m[i]) begin
                hit_hi = 1'b1;
                d_hi   = 3'(i);
            end
        end
        if (hit_lo) begin
            days_back = item_reg.weekday - d_lo;
        end else begin
            days_back = 3'({1'b0, item_reg.weekday} + 4'd7 - {1'b0, d_hi});
        end
        day_base = 16'(days_back) * MIN_PER_DAY;
        back_min = $signed(day_base) + 16'(diff);
        better   = pend_reg && pend_valid_reg && (hit_lo || hit_hi) && (back_min < best_reg);
    end

    // Mode and default setpoint updates of the command in hand
    always_comb begin
        heater_mode_next  = heater_mode_reg;
        default_temp_next = default_temp_reg;
        unique case (item_reg.operation)
            OP_SET_MODE: begin
                if (item_reg.mode_value != HEAT_RSVD) begin
                    heater_mode_next = item_reg.mode_value;
                end
            end
            OP_NEXT_MODE: begin
                priority if (heater_mode_reg == HEAT_AUTO) begin
                    heater_mode_next = HEAT_MANUAL;
                end else if (heater_mode_reg == HEAT_MANUAL) begin
                    heater_mode_next = HEAT_OFF;
                end else begin
                    heater_mode_next = HEAT_AUTO;
                end
            end
            OP_SET_MANUAL: begin
                heater_mode_next = HEAT_MANUAL;
                if ((item_reg.setpoint >= MANUAL_MIN) && (item_reg.setpoint <= MANUAL_MAX)) begin
                    default_temp_next = item_reg.setpoint;
                end
            end
            default: begin
            end
        endcase
    end

    // Result word
    always_comb begin
        result.source          = SRC_OFF;
        result.chosen_slot     = 3'd0;
        result.target_temp     = 9'd0;
        result.target_priority = 8'd0;
        result.mode_now        = heater_mode_next;
        if (item_reg.operation == OP_QUERY) begin
            priority if (heater_mode_reg == HEAT_AUTO && found_reg) begin
                result.source          = SRC_ENTRY;
                result.chosen_slot     = 3'(pick_reg);
                result.target_temp     = pick_temp_reg;
                result.target_priority = pick_prio_reg;
            end else if (heater_mode_reg == HEAT_AUTO || heater_mode_reg == HEAT_MANUAL) begin
                result.source          = SRC_DEFAULT;
                result.target_temp     = default_temp_reg;
                result.target_priority = DEFAULT_PRIO;
            end else begin
                result.source = SRC_OFF;
            end
        end
    end

    // Sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_data.operation == OP_QUERY && heater_mode_reg == HEAT_AUTO) begin
                        state_next = ST_SCAN;
                    end else begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_SCAN: begin
                if (cnt_reg == CW'(SLOTS)) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            cnt_reg          <= '0;
            pend_reg         <= 1'b0;
            found_reg        <= 1'b0;
            valid_bits_reg   <= '0;
            heater_mode_reg  <= HEAT_AUTO;
            default_temp_reg <= DEFAULT_TEMP_RST;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg <= state_next;

            // new command: arm the scan
            if (state_reg == ST_IDLE && s_valid) begin
                cnt_reg   <= '0;
                pend_reg  <= 1'b0;
                found_reg <= 1'b0;
            end

            // table walk, one slot per cycle
            if (state_reg == ST_SCAN) begin
                pend_reg <= (32'(cnt_reg) < SLOTS);
                if (32'(cnt_reg) < SLOTS) begin
                    cnt_reg <= cnt_reg + CW'(1);
                end
                if (better) begin
                    found_reg <= 1'b1;
                end
            end

            // commit the command and load the output word
            if (finish_go) begin
                heater_mode_reg  <= heater_mode_next;
                default_temp_reg <= default_temp_next;
                if (item_reg.operation == OP_WRITE_SLOT && slot_ok) begin
                    valid_bits_reg[slot_addr] <= 1'b1;
                end
                if (item_reg.operation == OP_DEL_SLOT && slot_ok) begin
                    valid_bits_reg[slot_addr] <= 1'b0;
                end
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && s_valid) begin
            item_reg <= s_data;
            now_reg  <= minutes_of(s_data.hour, s_data.minute);
            best_reg <= NO_DISTANCE;
        end
        if (state_reg == ST_SCAN) begin
            pend_valid_reg <= (32'(cnt_reg) < SLOTS) && valid_bits_reg[rd_addr];
            pend_idx_reg   <= rd_addr;
            if (better) begin
                best_reg      <= back_min;
                pick_reg      <= pend_idx_reg;
                pick_temp_reg <= rd_entry.temp;
                pick_prio_reg <= rd_entry.prio;
            end
        end
        if (finish_go) begin
            m_data_reg <= result;
        end
    end

    // Checks
    scan_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> (32'(cnt_reg) <= SLOTS))
        else $error("scan counter ran past the table");

    found_has_distance: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FINISH && found_reg) |-> (best_reg < NO_DISTANCE))
        else $error("entry picked without a distance");

    mode_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        heater_mode_reg != HEAT_RSVD)
        else $error("heater mode took the reserved code");

    default_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (default_temp_reg >= MANUAL_MIN) && (default_temp_reg <= MANUAL_MAX))
        else $error("default setpoint out of range");

    slot_only_for_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg.source != SRC_ENTRY) |-> (m_data_reg.chosen_slot == 3'd0))
        else $error("slot reported without a schedule entry");

    off_query_from_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        (finish_go && item_reg.operation == OP_QUERY && heater_mode_reg == HEAT_OFF)
        |=> (m_data_reg.source == SRC_OFF))
        else $error("query in off mode did not report off");

endmodule

[hw/rtl/wssl_ram.sv]
module wssl_ram #(
    parameter int WIDTH = 35,
    parameter int DEPTH = 8
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, registered read port
    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[test/weekly_setpoint_schedule_lookup_test.sv]
`timescale 1ns / 100ps

module weekly_setpoint_schedule_lookup_test;
    import wssl_pkg::*;

    localparam int SLOT_COUNT   = 8;
    localparam int DAY_MINUTES  = 1440;
    localparam int WEEK_MINUTES = 10080;

    // codes the block does not decode
    localparam logic [2:0] OP_SPARE_6 = 3'd6;
    localparam logic [2:0] OP_SPARE_7 = 3'd7;
    localparam logic [2:0] NO_WEEKDAY = 3'd7;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    wssl_in_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    wssl_out_t m_data;

    // predicted copy of the schedule table and heater state
    logic       tbl_valid [SLOT_COUNT];
    logic [6:0] tbl_days [SLOT_COUNT];
    logic [4:0] tbl_hour [SLOT_COUNT];
    logic [5:0] tbl_minute [SLOT_COUNT];
    logic [8:0] tbl_temp [SLOT_COUNT];
    logic [7:0] tbl_prio [SLOT_COUNT];
    logic [1:0] heater_mode_now;
    logic [8:0] default_setpoint;

    wssl_out_t answers_due [$];
    wssl_out_t answer_head;
    int        mismatches = 0;
    int        burst_left = 0;
    int        rx_hold    = 0;
    int        rx_phase   = 0;

    weekly_setpoint_schedule_lookup #(
        .SLOTS (SLOT_COUNT)
    ) u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Works out the answer word for one command and updates the predicted state
    function automatic wssl_out_t thermostat_answer(input wssl_in_t c);
        wssl_out_t r;
        int        now;
        int        day;
        int        at;
        int        back_min;
        int        best;
        int        d;
        int        i;
        int        pick;
        bit        hit;
        bit        found;
        r = '0;
        case (c.operation)
            OP_QUERY: begin
                if (heater_mode_now == HEAT_MANUAL) begin
                    r.source          = SRC_DEFAULT;
                    r.target_temp     = default_setpoint;
                    r.target_priority = DEFAULT_PRIO;
                end else if (heater_mode_now == HEAT_AUTO) begin
                    now   = int'(c.hour) * 60 + int'(c.minute);
                    day   = int'(c.weekday);
                    best  = NO_DISTANCE;
                    found = 1'b0;
                    pick  = 0;
                    for (i = 0; i < SLOT_COUNT; i++) begin
                        if (tbl_valid[i]) begin
                            at       = int'(tbl_hour[i]) * 60 + int'(tbl_minute[i]);
                            hit      = 1'b0;
                            back_min = 0;
                            // look back through this week first
                            for (d = day; d >= 0 && !hit; d--) begin
                                if (d <= 6 && tbl_days[i][d] && !(d == day && at > now)) begin
                                    hit      = 1'b1;
                                    back_min = (day - d) * DAY_MINUTES + now - at;
                                end
                            end
                            // then wrap round from the end of the week
                            for (d = 6; d >= day && !hit; d--) begin
                                if (tbl_days[i][d] && !(d == day && at < now)) begin
                                    hit      = 1'b1;
                                    back_min = WEEK_MINUTES - ((d - day) * DAY_MINUTES + at - now);
                                end
                            end
                            if (hit && back_min < best) begin
                                best  = back_min;
                                pick  = i;
                                found = 1'b1;
                            end
                        end
                    end
                    if (found) begin
                        r.source          = SRC_ENTRY;
                        r.chosen_slot     = 3'(pick);
                        r.target_temp     = tbl_temp[pick];
                        r.target_priority = tbl_prio[pick];
                    end else begin
                        r.source          = SRC_DEFAULT;
                        r.target_temp     = default_setpoint;
                        r.target_priority = DEFAULT_PRIO;
                    end
                end
            end
            OP_WRITE_SLOT: begin
                tbl_valid[c.slot]  = 1'b1;
                tbl_days[c.slot]   = c.day_mask;
                tbl_hour[c.slot]   = c.hour;
                tbl_minute[c.slot] = c.minute;
                tbl_temp[c.slot]   = c.setpoint;
                tbl_prio[c.slot]   = c.priority_req;
            end
            OP_DEL_SLOT: begin
                tbl_valid[c.slot] = 1'b0;
            end
            OP_SET_MODE: begin
                if (c.mode_value != HEAT_RSVD) begin
                    heater_mode_now = c.mode_value;
                end
            end
            OP_NEXT_MODE: begin
                case (heater_mode_now)
                    HEAT_AUTO:   heater_mode_now = HEAT_MANUAL;
                    HEAT_MANUAL: heater_mode_now = HEAT_OFF;
                    default:     heater_mode_now = HEAT_AUTO;
                endcase
            end
            OP_SET_MANUAL: begin
                heater_mode_now = HEAT_MANUAL;
                if (c.setpoint >= MANUAL_MIN && c.setpoint <= MANUAL_MAX) begin
                    default_setpoint = c.setpoint;
                end
            end
            default: ;
        endcase
        r.mode_now = heater_mode_now;
        return r;
    endfunction

    function automatic wssl_in_t command_word(input logic [2:0] op, input logic [2:0] slot,
                                              input logic [2:0] day, input logic [4:0] hr,
                                              input logic [5:0] mn, input logic [6:0] mask,
                                              input logic [8:0] sp, input logic [7:0] prio,
                                              input logic [1:0] mv);
        wssl_in_t w;
        w.operation    = op;
        w.slot         = slot;
        w.weekday      = day;
        w.hour         = hr;
        w.minute       = mn;
        w.day_mask     = mask;
        w.setpoint     = sp;
        w.priority_req = prio;
        w.mode_value   = mv;
        return w;
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%t mismatch on %s: expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endfunction

    // Sends one command word; called just after a falling edge, returns after one
    task automatic send_word(input wssl_in_t w);
        int gap;
        // bursts of random length with random gaps between them
        if (burst_left == 0) begin
            gap = ($urandom_range(1) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        s_data  <= w;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        answers_due.push_back(thermostat_answer(w));
        @(negedge aclk);
    endtask

    // Holds the sender off until every predicted answer has come back
    task automatic wait_all_answered();
        s_valid <= 1'b0;
        while (answers_due.size() != 0) @(negedge aclk);
    endtask

    // Result checker
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (answers_due.size() == 0) begin
                $display("%t unexpected result: expected none, actual %h", $time, m_data);
                mismatches++;
            end else begin
                answer_head = answers_due.pop_front();
                check_field("source", answer_head.source, m_data.source);
                check_field("chosen_slot", answer_head.chosen_slot, m_data.chosen_slot);
                check_field("target_temp", answer_head.target_temp, m_data.target_temp);
                check_field("target_priority", answer_head.target_priority,
                            m_data.target_priority);
                check_field("mode_now", answer_head.mode_now, m_data.mode_now);
            end
        end
    end

    // Receiver: a calm stretch, then random stalls of varying length
    always @(negedge aclk) begin
        rx_phase = (rx_phase + 1) % 300;
        if (rx_hold > 0) begin
            rx_hold--;
            m_ready <= 1'b0;
        end else if (rx_phase >= 80 && $urandom_range(3) == 0) begin
            rx_hold = $urandom_range(0, 14);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // After reset: empty table in AUTO mode answers with the default
    task automatic test_reset_defaults();
        send_word(command_word(OP_QUERY, 0, 0, 0, 0, 0, 0, 0, HEAT_OFF));
    endtask

    // Mode setting, the reserved mode value and the mode cycle
    task automatic test_mode_changes();
        send_word(command_word(OP_SET_MODE, 0, 0, 0, 0, 0, 0, 0, HEAT_OFF));
        send_word(command_word(OP_QUERY, 7, 6, 23, 59, 7'h7f, 9'h1ff, 8'hff, HEAT_RSVD));
        send_word(command_word(OP_SET_MODE, 0, 0, 0, 0, 0, 0, 0, HEAT_RSVD));
        send_word(command_word(OP_NEXT_MODE, 0, 0, 0, 0, 0, 0, 0, HEAT_OFF));
        send_word(command_word(OP_NEXT_MODE, 0, 0, 0, 0, 0, 0, 0, HEAT_OFF));
        send_word(command_word(OP_QUERY, 0, 3, 12, 0, 0, 0, 0, HEAT_OFF));
        send_word(command_word(OP_NEXT_MODE, 0, 0, 0, 0, 0, 0, 0, HEAT_OFF));
    endtask

    // Manual setpoint: limits of the accepted range and just outside them
    task automatic test_manual_setpoint();
        send_word(command_word(OP_SET_MANUAL, 0, 0, 0, 0, 0, 69, 0, HEAT_OFF));
        send_word(command_word(OP_SET_MANUAL, 0, 0, 0, 0, 0, 70, 0, HEAT_OFF));
        send_word(command_word(OP_SET_MANUAL, 0, 0, 0, 0, 0, 261, 0, HEAT_OFF));
        send_word(command_word(OP_SET_MANUAL, 0, 0, 0, 0, 0, 260, 0, HEAT_OFF));
        send_word(command_word(OP_QUERY, 0, 0, 0, 0, 0, 0, 0, HEAT_OFF));
        send_word(command_word(OP_SET_MANUAL, 0, 0, 0, 0, 0, 9'h1ff, 0, HEAT_OFF));
    endtask

    // Schedule search: ties, week wrap, unused weekday, out-of-range times, spare codes
    task automatic test_schedule_search();
        send_word(command_word(OP_SET_MODE, 0, 0, 0, 0, 0, 0, 0, HEAT_AUTO));
        send_word(command_word(OP_WRITE_SLOT, 0, 0, 6, 30, 7'h7f, 200, 8'hff, HEAT_OFF));
        send_word(command_word(OP_WRITE_SLOT, 7, 0, 23, 59, 7'h01, 9'h1ff, 0, HEAT_OFF));
        send_word(command_word(OP_WRITE_SLOT, 3, 0, 6, 30, 7'h01, 180, 40, HEAT_OFF));
        // same distance for slots 0 and 3: lowest slot wins
        send_word(command_word(OP_QUERY, 0, 0, 6, 30, 0, 0, 0, HEAT_OFF));
        // midnight on weekday 0 wraps back to the end of the week
        send_word(command_word(OP_QUERY, 0, 0, 0, 0, 0, 0, 0, HEAT_OFF));
        send_word(command_word(OP_QUERY, 0, NO_WEEKDAY, 31, 63, 0, 0, 0, HEAT_OFF));
        // an entry past the end of its day gives a negative distance the next day
        send_word(command_word(OP_WRITE_SLOT, 5, 0, 31, 63, 7'h7f, 300, 77, HEAT_OFF));
        send_word(command_word(OP_QUERY, 0, 1, 0, 0, 0, 0, 0, HEAT_OFF));
        send_word(command_word(OP_DEL_SLOT, 5, 0, 0, 0, 0, 0, 0, HEAT_OFF));
        send_word(command_word(OP_DEL_SLOT, 0, 0, 0, 0, 0, 0, 0, HEAT_OFF));
        send_word(command_word(OP_QUERY, 0, 0, 6, 30, 0, 0, 0, HEAT_OFF));
        send_word(command_word(OP_SPARE_6, 4, 2, 10, 10, 7'h7f, 100, 5, HEAT_MANUAL));
        send_word(command_word(OP_SPARE_7, 4, 2, 10, 10, 7'h7f, 100, 5, HEAT_MANUAL));
    endtask

    // Random traffic: rounds that start in AUTO mode, mostly well-formed times
    task automatic test_random_traffic(input int count);
        wssl_in_t    w;
        logic [63:0] noise;
        int          roll;
        int          n;
        for (n = 0; n < count; n++) begin
            noise = {$urandom, $urandom};
            w     = noise[$bits(wssl_in_t)-1:0];
            roll  = $urandom_range(99);
            if (n % 16 == 0) begin
                w.operation  = OP_SET_MODE;
                w.mode_value = HEAT_AUTO;
            end else if (roll < 50) begin
                w.operation = OP_QUERY;
            end else if (roll < 72) begin
                w.operation = OP_WRITE_SLOT;
            end else if (roll < 80) begin
                w.operation = OP_DEL_SLOT;
            end else if (roll < 85) begin
                w.operation = OP_SET_MODE;
            end else if (roll < 89) begin
                w.operation = OP_NEXT_MODE;
            end else if (roll < 95) begin
                w.operation = OP_SET_MANUAL;
            end
            // otherwise the noise operation stands, spare codes included
            if ($urandom_range(9) != 0) begin
                w.weekday = 3'($urandom_range(6));
                if ($urandom_range(2) == 0) begin
                    // a few clustered times so that ties come up
                    w.hour   = 5'($urandom_range(3) * 6);
                    w.minute = 6'($urandom_range(2) * 29);
                end else begin
                    w.hour   = 5'($urandom_range(23));
                    w.minute = 6'($urandom_range(59));
                end
                if (w.operation == OP_SET_MANUAL) begin
                    w.setpoint = 9'($urandom_range(60, 270));
                end
                if (w.operation == OP_SET_MODE && n % 16 != 0) begin
                    w.mode_value = 2'($urandom_range(2));
                end
            end
            if (n == count / 2) begin
                wait_all_answered();
            end
            send_word(w);
        end
    endtask

    initial begin
        for (int i = 0; i < SLOT_COUNT; i++) begin
            tbl_valid[i] = 1'b0;
            tbl_days[i]  = '0;
            tbl_temp[i]  = 9'd170;
            tbl_prio[i]  = DEFAULT_PRIO;
        end
        heater_mode_now  = HEAT_AUTO;
        default_setpoint = DEFAULT_TEMP_RST;

        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;

        test_reset_defaults();
        test_mode_changes();
        test_manual_setpoint();
        test_schedule_search();
        wait_all_answered();
        test_random_traffic(480);
        wait_all_answered();
        repeat (20) @(negedge aclk);

        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
